// ----- hw/rtl/dipa_pkg.sv -----
// Shared types, character codes and the digit decode for the dotted IPv4 address parser.
// Used by dipa_core and dotted_ipv4_address_parser; no dependencies.
package dipa_pkg;

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_ZERO  = 2'd1,
      PH_HEX0  = 2'd2,
      PH_DIGIT = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_HEX = 2'd2,
      RADIX_RSV = 2'd3
   } radix_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] address;
      logic        status;
   } result_type;

   localparam logic [7:0]  CH_NUL   = 8'h00;
   localparam logic [7:0]  CH_DOT   = 8'h2e;
   localparam logic [7:0]  CH_ZERO  = 8'h30;
   localparam logic [7:0]  CH_ONE   = 8'h31;
   localparam logic [7:0]  CH_NINE  = 8'h39;
   localparam logic [7:0]  CH_LX    = 8'h78;
   localparam logic [7:0]  CH_UX    = 8'h58;
   localparam logic [7:0]  CH_LA    = 8'h61;
   localparam logic [7:0]  CH_LF    = 8'h66;
   localparam logic [7:0]  CH_UA    = 8'h41;
   localparam logic [7:0]  CH_UF    = 8'h46;

   localparam logic [31:0] ALL_ONES = 32'hffff_ffff;
   localparam logic [31:0] LIMIT_24 = 32'h00ff_ffff;
   localparam logic [31:0] LIMIT_16 = 32'h0000_ffff;
   localparam logic [31:0] LIMIT_8  = 32'h0000_00ff;

   // {valid, value}; valid low for anything that is not a hex digit
   function automatic logic [4:0] char_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         r = {1'b1, 4'(c - CH_ZERO)};
      end else if (c >= CH_LA && c <= CH_LF) begin
         r = {1'b1, 4'(c - CH_LA + 8'd10)};
      end else if (c >= CH_UA && c <= CH_UF) begin
         r = {1'b1, 4'(c - CH_UA + 8'd10)};
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/dotted_ipv4_address_parser.sv -----
// Channel  | Direction | Ports                              | Transfer
// req      | in        | req_valid req_ready req_char_code  | one character
// rsp      | out       | rsp_valid rsp_ready rsp_address rsp_status | one parsed address
// One character per cycle unless a terminator stalls (see below); each character is registered,
// then stepped through dipa_core, and a terminator's result is registered in the result register.
// Reset is synchronous and returns the parser to the start of a new string.
// A terminator stalls in the input register only while the result register is full
// and not being drained; other characters never stall.
// Depends on dipa_pkg and dipa_core.
module dotted_ipv4_address_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_address,
   output logic        rsp_status
);

   logic        in_valid_ff;
   logic [7:0]  in_char_ff;
   logic        out_valid_ff;
   logic [31:0] out_addr_ff;
   logic        out_status_ff;
   logic        out_free, advance;
   dipa_pkg::result_type result;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!result.valid || out_free);
   assign req_ready = !in_valid_ff || advance;

   dipa_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .char_code (in_char_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_char_ff <= req_char_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && result.valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         out_addr_ff   <= result.address;
         out_status_ff <= result.status;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_address = out_addr_ff;
   assign rsp_status  = out_status_ff;

   a_bad_all_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_address == dipa_pkg::ALL_ONES)
      else $error("invalid result with address not all ones");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && result.valid && out_valid_ff && !rsp_ready)
      else $error("input stalled without a blocked result");

   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      advance && result.valid |=> rsp_valid)
      else $error("stepped result not presented");

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_address))
      else $error("pending result dropped or changed");

endmodule

// ----- hw/rtl/dipa_core.sv -----
// Parser state and per-character step logic: phase machine, part accumulator, part store.
// Depends on dipa_pkg.
module dipa_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic [7:0]           char_code,
   output dipa_pkg::result_type result
);

   dipa_pkg::phase_type phase_ff, phase_in;
   dipa_pkg::radix_type radix_ff, radix_in;
   logic [31:0] acc_ff, acc_in;
   logic        ovf_ff, ovf_in;
   logic        err_ff, err_in;
   logic [1:0]  count_ff, count_in;
   logic [7:0]  part_store_ff [3];

   logic [4:0]  dig;
   logic        is_nul, is_dot, is_x, is_lead0, is_nz;
   logic        in_radix, dot_ok;
   logic [35:0] acc_mul, acc_next;
   logic        fin, fin_bad, store;
   logic [31:0] limit, high;

   assign dig      = dipa_pkg::char_digit(char_code);
   assign is_nul   = char_code == dipa_pkg::CH_NUL;
   assign is_dot   = char_code == dipa_pkg::CH_DOT;
   assign is_x     = char_code == dipa_pkg::CH_LX || char_code == dipa_pkg::CH_UX;
   assign is_lead0 = char_code == dipa_pkg::CH_ZERO;
   assign is_nz    = char_code >= dipa_pkg::CH_ONE && char_code <= dipa_pkg::CH_NINE;
   assign dot_ok   = is_dot && count_ff < 2'd3 && !ovf_ff && acc_ff[31:8] == 24'd0;

   always_comb begin
      case (radix_ff)
         dipa_pkg::RADIX_OCT: begin
            in_radix = dig[4] && dig[3:0] < 4'd8;
            acc_mul  = {1'b0, acc_ff, 3'd0};
         end
         dipa_pkg::RADIX_HEX: begin
            in_radix = dig[4];
            acc_mul  = {acc_ff, 4'd0};
         end
         default: begin
            in_radix = dig[4] && dig[3:0] < 4'd10;
            acc_mul  = {1'b0, acc_ff, 3'd0} + {3'd0, acc_ff, 1'b0};
         end
      endcase
   end

   assign acc_next = acc_mul + {32'd0, dig[3:0]};

   // next state: phase, error flag and the actions taken by this character
   always_comb begin
      phase_in = phase_ff;
      err_in   = err_ff;
      fin      = 1'b0;
      fin_bad  = 1'b0;
      store    = 1'b0;
      if (err_ff) begin
         fin     = is_nul;
         fin_bad = 1'b1;
      end else begin
         unique case (phase_ff)
            dipa_pkg::PH_START: begin
               if (is_lead0) begin
                  phase_in = dipa_pkg::PH_ZERO;
               end else if (is_nz) begin
                  phase_in = dipa_pkg::PH_DIGIT;
               end else if (is_nul) begin
                  fin     = 1'b1;
                  fin_bad = 1'b1;
               end else begin
                  err_in = 1'b1;
               end
            end
            dipa_pkg::PH_HEX0: begin
               if (dig[4]) begin
                  phase_in = dipa_pkg::PH_DIGIT;
               end else if (is_nul) begin
                  fin     = 1'b1;
                  fin_bad = 1'b1;
               end else begin
                  err_in = 1'b1;
               end
            end
            dipa_pkg::PH_ZERO, dipa_pkg::PH_DIGIT: begin
               if (phase_ff == dipa_pkg::PH_ZERO && is_x) begin
                  phase_in = dipa_pkg::PH_HEX0;
               end else if (phase_ff == dipa_pkg::PH_ZERO && dig[4] && dig[3:0] < 4'd8) begin
                  phase_in = dipa_pkg::PH_DIGIT;
               end else if (phase_ff == dipa_pkg::PH_DIGIT && in_radix) begin
                  phase_in = dipa_pkg::PH_DIGIT;
               end else if (is_nul) begin
                  fin = 1'b1;
               end else if (dot_ok) begin
                  store    = 1'b1;
                  phase_in = dipa_pkg::PH_START;
               end else begin
                  err_in = 1'b1;
               end
            end
            default: begin
               err_in = 1'b1;
            end
         endcase
      end
      if (fin) begin
         phase_in = dipa_pkg::PH_START;
         err_in   = 1'b0;
      end
   end

   // datapath: accumulator, radix, overflow, part count and the result
   always_comb begin
      acc_in   = acc_ff;
      radix_in = radix_ff;
      ovf_in   = ovf_ff;
      count_in = count_ff;
      if (fin || store) begin
         acc_in   = 32'd0;
         radix_in = dipa_pkg::RADIX_DEC;
         ovf_in   = 1'b0;
         count_in = fin ? 2'd0 : count_ff + 2'd1;
      end else if (!err_ff) begin
         unique case (phase_ff)
            dipa_pkg::PH_START: begin
               if (is_lead0) begin
                  acc_in = 32'd0;
               end else if (is_nz) begin
                  acc_in   = {28'd0, dig[3:0]};
                  radix_in = dipa_pkg::RADIX_DEC;
               end
            end
            dipa_pkg::PH_ZERO: begin
               if (is_x) begin
                  radix_in = dipa_pkg::RADIX_HEX;
               end else if (dig[4] && dig[3:0] < 4'd8) begin
                  acc_in   = {28'd0, dig[3:0]};
                  radix_in = dipa_pkg::RADIX_OCT;
               end
            end
            dipa_pkg::PH_HEX0: begin
               if (dig[4]) begin
                  acc_in = {28'd0, dig[3:0]};
               end
            end
            dipa_pkg::PH_DIGIT: begin
               if (in_radix) begin
                  acc_in = acc_next[31:0];
                  ovf_in = ovf_ff | (acc_next[35:32] != 4'd0);
               end
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end

      case (count_ff)
         2'd1: begin
            limit = dipa_pkg::LIMIT_24;
            high  = {part_store_ff[0], 24'd0};
         end
         2'd2: begin
            limit = dipa_pkg::LIMIT_16;
            high  = {part_store_ff[0], part_store_ff[1], 16'd0};
         end
         2'd3: begin
            limit = dipa_pkg::LIMIT_8;
            high  = {part_store_ff[0], part_store_ff[1], part_store_ff[2], 8'd0};
         end
         default: begin
            limit = dipa_pkg::ALL_ONES;
            high  = 32'd0;
         end
      endcase

      result.valid = fin;
      if (!fin_bad && !ovf_ff && acc_ff <= limit) begin
         result.address = acc_ff | high;
         result.status  = 1'b0;
      end else begin
         result.address = dipa_pkg::ALL_ONES;
         result.status  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= dipa_pkg::PH_START;
         radix_ff         <= dipa_pkg::RADIX_DEC;
         acc_ff           <= 32'd0;
         ovf_ff           <= 1'b0;
         err_ff           <= 1'b0;
         count_ff         <= 2'd0;
         part_store_ff[0] <= 8'd0;
         part_store_ff[1] <= 8'd0;
         part_store_ff[2] <= 8'd0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         radix_ff <= radix_in;
         acc_ff   <= acc_in;
         ovf_ff   <= ovf_in;
         err_ff   <= err_in;
         count_ff <= count_in;
         if (fin) begin
            part_store_ff[0] <= 8'd0;
            part_store_ff[1] <= 8'd0;
            part_store_ff[2] <= 8'd0;
         end else if (store) begin
            part_store_ff[count_ff] <= acc_ff[7:0];
         end
      end
   end

endmodule
